// ----- rtl/ort_pkg.sv -----
// Shared types, constants and helpers for the observation registration table.
package ort_pkg;

    localparam int TABLE_ENTRIES_DEF   = 32;
    localparam int TOKEN_MAX_BYTES_DEF = 8;

    localparam int ID_W    = 16;
    localparam int PATH_W  = 64;
    localparam int LEN_W   = 4;
    localparam int TOKEN_W = 64;
    localparam int STAT_W  = 3;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_ALREADY   = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_COMMIT
    } state_t;

    function automatic logic [TOKEN_W-1:0] token_mask(input logic [LEN_W-1:0] len);
        logic [TOKEN_W-1:0] m;
        m = '0;
        for (int b = 0; b < TOKEN_W / 8; b++)
        begin
            if (LEN_W'(b) < len)
            begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// ----- rtl/ort_ram.sv -----
// Generic single-clock RAM, one write port and one registered read port.
module ort_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/observe_registration_table.sv -----
// Observation registration table: top level with scan sequencer around one table RAM.
//
// Command channel: an item (cmd, client_id, resource path, token) is taken at a
// rising edge where start is high and busy is low. Insert looks for a valid entry
// with the same client and path; on a hit it reports already registered with the
// stored token, otherwise it fills the lowest free slot or reports table full.
// Delete clears the matching entry or reports not found.
// Result channel: done is high for exactly one cycle with status,
// found_token_length and found_token_bytes; the receiver cannot stall it.
// Sequence: after the accepting edge the scan reads one table entry per cycle
// through the RAM's single read port, then a commit state writes the table, and
// done is registered from the commit state. busy drops in the done cycle, so a new
// item is taken only once the last one has given its result; items never overlap.
// Reset: a clearing pass writes every entry invalid with busy high; no item is
// taken until it ends.
// Items are handled one at a time, so the commit write always lands before the
// next scan reads the table.
module observe_registration_table #(
    parameter int TABLE_ENTRIES   = ort_pkg::TABLE_ENTRIES_DEF,
    parameter int TOKEN_MAX_BYTES = ort_pkg::TOKEN_MAX_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        cmd,
    input  logic [ort_pkg::ID_W-1:0]    client_id,
    input  logic [ort_pkg::ID_W-1:0]    object_id,
    input  logic [ort_pkg::ID_W-1:0]    instance_id,
    input  logic [ort_pkg::ID_W-1:0]    resource_id,
    input  logic [ort_pkg::ID_W-1:0]    resource_instance_id,
    input  logic [ort_pkg::LEN_W-1:0]   token_length,
    input  logic [ort_pkg::TOKEN_W-1:0] token_bytes,
    output logic                        done,
    output logic [ort_pkg::STAT_W-1:0]  status,
    output logic [ort_pkg::LEN_W-1:0]   found_token_length,
    output logic [ort_pkg::TOKEN_W-1:0] found_token_bytes
);

    import ort_pkg::*;

    localparam int ADDR_W     = $clog2(TABLE_ENTRIES);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int TOK_W      = 8 * TOKEN_MAX_BYTES;
    localparam int WORD_W     = 1 + ID_W + PATH_W + LEN_W + TOK_W;
    localparam int LEN_LSB    = TOK_W;
    localparam int PATH_LSB   = LEN_LSB + LEN_W;
    localparam int CLIENT_LSB = PATH_LSB + PATH_W;
    localparam int VALID_BIT  = WORD_W - 1;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                cmd_reg;
    logic [ID_W-1:0]     client_reg;
    logic [PATH_W-1:0]   path_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [TOK_W-1:0]    tok_reg;
    logic                hit_reg;
    logic [ADDR_W-1:0]   hit_idx_reg;
    logic [LEN_W-1:0]    hit_len_reg;
    logic [TOK_W-1:0]    hit_tok_reg;
    logic                free_reg;
    logic [ADDR_W-1:0]   free_idx_reg;
    logic                done_reg;
    status_t             status_reg;
    logic [LEN_W-1:0]    flen_reg;
    logic [TOKEN_W-1:0]  ftok_reg;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    logic                accept;
    logic [LEN_W-1:0]    len_sat;
    logic [TOKEN_W-1:0]  tok_masked;
    logic [CNT_W-1:0]    prev_cnt;
    logic [ADDR_W-1:0]   rd_idx;
    logic                scan_live;
    logic                rd_match;
    logic                rd_free;
    status_t             commit_status;

    ort_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign len_sat    = (token_length > LEN_W'(TOKEN_MAX_BYTES)) ?
                        LEN_W'(TOKEN_MAX_BYTES) : token_length;
    assign tok_masked = token_bytes & token_mask(len_sat);

    assign prev_cnt  = cnt_reg - 1'b1;
    assign rd_idx    = prev_cnt[ADDR_W-1:0];
    assign scan_live = (state_reg == S_SCAN) && (cnt_reg != '0);
    assign rd_match  = ram_rdata[VALID_BIT]
                    && (ram_rdata[CLIENT_LSB +: ID_W] == client_reg)
                    && (ram_rdata[PATH_LSB +: PATH_W] == path_reg);
    assign rd_free   = !ram_rdata[VALID_BIT];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (cnt_reg == CNT_W'(TABLE_ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == CNT_W'(TABLE_ENTRIES))
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next      = '0;
        ram_we        = 1'b0;
        ram_waddr     = cnt_reg[ADDR_W-1:0];
        ram_wdata     = '0;
        ram_raddr     = cnt_reg[ADDR_W-1:0];
        commit_status = ST_NOT_FOUND;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                if (state_next == S_CLEAR)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                if (state_next == S_SCAN)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_COMMIT:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    if (hit_reg)
                    begin
                        commit_status = ST_ALREADY;
                    end
                    else if (free_reg)
                    begin
                        ram_we        = 1'b1;
                        ram_waddr     = free_idx_reg;
                        ram_wdata     = {1'b1, client_reg, path_reg, len_reg, tok_reg};
                        commit_status = ST_INSERTED;
                    end
                    else
                    begin
                        commit_status = ST_FULL;
                    end
                end
                else if (hit_reg)
                begin
                    ram_we        = 1'b1;
                    ram_waddr     = hit_idx_reg;
                    commit_status = ST_DELETED;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= (state_reg == S_COMMIT);
            if (accept)
            begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else if (scan_live)
            begin
                if (rd_match)
                begin
                    hit_reg <= 1'b1;
                end
                if (rd_free)
                begin
                    free_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            client_reg <= client_id;
            path_reg   <= {object_id, instance_id, resource_id, resource_instance_id};
            len_reg    <= len_sat;
            tok_reg    <= tok_masked[TOK_W-1:0];
        end
        if (scan_live && rd_match && !hit_reg)
        begin
            hit_idx_reg <= rd_idx;
            hit_len_reg <= ram_rdata[LEN_LSB +: LEN_W];
            hit_tok_reg <= ram_rdata[TOK_W-1:0];
        end
        if (scan_live && rd_free && !free_reg)
        begin
            free_idx_reg <= rd_idx;
        end
        if (state_reg == S_COMMIT)
        begin
            status_reg <= commit_status;
            if (commit_status == ST_ALREADY)
            begin
                flen_reg <= hit_len_reg;
                ftok_reg <= TOKEN_W'(hit_tok_reg);
            end
            else
            begin
                flen_reg <= '0;
                ftok_reg <= '0;
            end
        end
    end

    assign done               = done_reg;
    assign status             = status_reg;
    assign found_token_length = flen_reg;
    assign found_token_bytes  = ftok_reg;

`ifndef ASSERT_OFF
    a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_COMMIT))
        else $error("result strobe without a commit cycle");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && (state_reg == S_SCAN))
        else $error("accepted item did not start a scan");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !ram_we)
        else $error("table write during scan");

    a_full_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status_reg == ST_FULL)) |-> (cmd_reg == CMD_INSERT) && !hit_reg)
        else $error("table full reported for a delete or a hit");
`endif

endmodule

// ----- dv/observe_registration_table_tb.sv -----
// Testbench for the observation registration table: directed rows, fill, random traffic.
module observe_registration_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ort_pkg::*;

    localparam int ENTRIES        = TABLE_ENTRIES_DEF;
    localparam int TOKEN_MAX      = TOKEN_MAX_BYTES_DEF;
    localparam int KEY_POOL       = ENTRIES + 12;
    localparam int RANDOM_ITEMS   = 300;
    localparam int QUIET_TAIL     = 60;
    localparam int WATCHDOG_LIMIT = 20 * (ENTRIES + 3);
    localparam int REPORT_CAP     = 50;

    typedef struct packed {
        logic                cmd;
        logic [ID_W-1:0]     client;
        logic [ID_W-1:0]     obj_id;
        logic [ID_W-1:0]     inst_id;
        logic [ID_W-1:0]     res_id;
        logic [ID_W-1:0]     rinst_id;
        logic [LEN_W-1:0]    len;
        logic [TOKEN_W-1:0]  bytes;
    } request_t;

    typedef struct packed {
        status_t             status;
        logic [LEN_W-1:0]    flen;
        logic [TOKEN_W-1:0]  fbytes;
    } result_t;

    typedef struct packed {
        request_t            req;
        logic                known;
        result_t             want;
    } row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                cmd = CMD_INSERT;
    logic [ID_W-1:0]     client_id = '0;
    logic [ID_W-1:0]     object_id = '0;
    logic [ID_W-1:0]     instance_id = '0;
    logic [ID_W-1:0]     resource_id = '0;
    logic [ID_W-1:0]     resource_instance_id = '0;
    logic [LEN_W-1:0]    token_length = '0;
    logic [TOKEN_W-1:0]  token_bytes = '0;
    logic                done;
    logic [STAT_W-1:0]   status;
    logic [LEN_W-1:0]    found_token_length;
    logic [TOKEN_W-1:0]  found_token_bytes;

    logic                reg_valid [ENTRIES];
    logic [ID_W-1:0]     reg_client [ENTRIES];
    logic [PATH_W-1:0]   reg_path [ENTRIES];
    logic [LEN_W-1:0]    reg_len [ENTRIES];
    logic [TOKEN_W-1:0]  reg_token [ENTRIES];

    result_t             pending_results [$];
    row_t                directed_rows [$];
    request_t            key_pool [KEY_POOL];
    int                  mismatch_count = 0;
    int                  items_sent = 0;
    int                  idle_cycles = 0;
    int                  status_seen [8];
    bit                  idle_on = 1'b1;

    observe_registration_table dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .cmd                  (cmd),
        .client_id            (client_id),
        .object_id            (object_id),
        .instance_id          (instance_id),
        .resource_id          (resource_id),
        .resource_instance_id (resource_instance_id),
        .token_length         (token_length),
        .token_bytes          (token_bytes),
        .done                 (done),
        .status               (status),
        .found_token_length   (found_token_length),
        .found_token_bytes    (found_token_bytes)
    );

    always #6 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_CAP)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    function automatic result_t apply_registration(input request_t r);
        result_t           res;
        logic [PATH_W-1:0] path;
        logic [LEN_W-1:0]  len;
        logic [TOKEN_W-1:0] mask;
        int                hit;
        int                slot;
        res.status = ST_NOT_FOUND;
        res.flen   = '0;
        res.fbytes = '0;
        path = {r.obj_id, r.inst_id, r.res_id, r.rinst_id};
        len  = (r.len > LEN_W'(TOKEN_MAX)) ? LEN_W'(TOKEN_MAX) : r.len;
        mask = (len >= 4'd8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
        hit  = -1;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit < 0 && reg_valid[i] && reg_client[i] == r.client && reg_path[i] == path)
            begin
                hit = i;
            end
            if (slot < 0 && !reg_valid[i])
            begin
                slot = i;
            end
        end
        if (r.cmd == CMD_INSERT)
        begin
            if (hit >= 0)
            begin
                res.status = ST_ALREADY;
                res.flen   = reg_len[hit];
                res.fbytes = reg_token[hit];
            end
            else if (slot >= 0)
            begin
                reg_valid[slot]  = 1'b1;
                reg_client[slot] = r.client;
                reg_path[slot]   = path;
                reg_len[slot]    = len;
                reg_token[slot]  = r.bytes & mask;
                res.status = ST_INSERTED;
            end
            else
            begin
                res.status = ST_FULL;
            end
        end
        else if (hit >= 0)
        begin
            reg_valid[hit] = 1'b0;
            res.status = ST_DELETED;
        end
        return res;
    endfunction

    function automatic void add_row(input logic c, input logic [15:0] cl, input logic [15:0] o,
                                    input logic [15:0] i, input logic [15:0] rs,
                                    input logic [15:0] ri, input logic [3:0] len,
                                    input logic [63:0] bytes, input logic known,
                                    input status_t st, input logic [3:0] flen,
                                    input logic [63:0] fbytes);
        row_t row;
        row.req   = '{c, cl, o, i, rs, ri, len, bytes};
        row.known = known;
        row.want  = '{st, flen, fbytes};
        directed_rows.push_back(row);
    endfunction

    function automatic request_t token_request(input request_t key, input logic c);
        request_t r;
        r       = key;
        r.cmd   = c;
        r.len   = LEN_W'($urandom_range(0, 15));
        r.bytes = {$urandom, $urandom};
        return r;
    endfunction

    task automatic send_request(input request_t r, input logic known, input result_t want);
        result_t predicted;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        cmd                  <= r.cmd;
        client_id            <= r.client;
        object_id            <= r.obj_id;
        instance_id          <= r.inst_id;
        resource_id          <= r.res_id;
        resource_instance_id <= r.rinst_id;
        token_length         <= r.len;
        token_bytes          <= r.bytes;
        start                <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_registration(r);
        pending_results.push_back(known ? want : predicted);
        items_sent++;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            idle_cycles <= ((start && !busy) || done) ? 0 : idle_cycles + 1;
            if (done)
            begin
                status_seen[status]++;
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("result with no item pending, status %0d", status));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status)
                    begin
                        report_mismatch($sformatf("status %0d, want %s", status,
                                                  want.status.name()));
                    end
                    if (found_token_length !== want.flen)
                    begin
                        report_mismatch($sformatf("found_token_length %0d, want %0d",
                                                  found_token_length, want.flen));
                    end
                    if (found_token_bytes !== want.fbytes)
                    begin
                        report_mismatch($sformatf("found_token_bytes %h, want %h",
                                                  found_token_bytes, want.fbytes));
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", idle_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        request_t r;
        request_t fill_key;
        result_t  none;
        int       n;
        logic     do_insert;
        none = '{ST_INSERTED, 4'd0, 64'd0};
        for (int i = 0; i < ENTRIES; i++)
        begin
            reg_valid[i] = 1'b0;
        end
        for (int s = 0; s < 8; s++)
        begin
            status_seen[s] = 0;
        end

        add_row(CMD_DELETE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd0,
                64'h0, 1, ST_NOT_FOUND, 4'd0, 64'h0);
        add_row(CMD_INSERT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd0,
                64'hFFFF_FFFF_FFFF_FFFF, 1, ST_INSERTED, 4'd0, 64'h0);
        add_row(CMD_INSERT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd5,
                64'h1111_1111_1111_1111, 1, ST_ALREADY, 4'd0, 64'h0);
        add_row(CMD_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd8,
                64'hFFFF_FFFF_FFFF_FFFF, 1, ST_INSERTED, 4'd0, 64'h0);
        add_row(CMD_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd0,
                64'h0, 1, ST_ALREADY, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
        add_row(CMD_INSERT, 16'h1234, 16'h0003, 16'h0000, 16'h0001, 16'h0000, 4'd15,
                64'h0123_4567_89AB_CDEF, 1, ST_INSERTED, 4'd0, 64'h0);
        add_row(CMD_INSERT, 16'h1234, 16'h0003, 16'h0000, 16'h0001, 16'h0000, 4'd2,
                64'h0, 1, ST_ALREADY, 4'd8, 64'h0123_4567_89AB_CDEF);
        add_row(CMD_INSERT, 16'h1234, 16'h0003, 16'h0000, 16'h0001, 16'h0001, 4'd3,
                64'hFFFF_FFFF_FFFF_FFFF, 1, ST_INSERTED, 4'd0, 64'h0);
        add_row(CMD_INSERT, 16'h1234, 16'h0003, 16'h0000, 16'h0001, 16'h0001, 4'd7,
                64'h0, 1, ST_ALREADY, 4'd3, 64'h0000_0000_00FF_FFFF);
        add_row(CMD_INSERT, 16'h4321, 16'h0003, 16'h0000, 16'h0001, 16'h0000, 4'd9,
                64'hA5A5_A5A5_A5A5_A5A5, 1, ST_INSERTED, 4'd0, 64'h0);
        add_row(CMD_INSERT, 16'h4321, 16'h0003, 16'h0000, 16'h0001, 16'h0000, 4'd1,
                64'h0, 1, ST_ALREADY, 4'd8, 64'hA5A5_A5A5_A5A5_A5A5);
        add_row(CMD_DELETE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15,
                64'hFFFF_FFFF_FFFF_FFFF, 1, ST_DELETED, 4'd0, 64'h0);
        add_row(CMD_DELETE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd8,
                64'h0, 1, ST_NOT_FOUND, 4'd0, 64'h0);
        add_row(CMD_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd1,
                64'h5A5A_5A5A_5A5A_5A5A, 1, ST_INSERTED, 4'd0, 64'h0);
        add_row(CMD_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd0,
                64'h0, 1, ST_ALREADY, 4'd1, 64'h0000_0000_0000_005A);
        add_row(CMD_DELETE, 16'h1234, 16'h0003, 16'h0000, 16'h0001, 16'h0000, 4'd0,
                64'h0, 1, ST_DELETED, 4'd0, 64'h0);
        add_row(CMD_INSERT, 16'h1234, 16'h0003, 16'h0000, 16'h0001, 16'h0001, 4'd0,
                64'h0, 1, ST_ALREADY, 4'd3, 64'h0000_0000_00FF_FFFF);
        add_row(CMD_DELETE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd0,
                64'h0, 1, ST_DELETED, 4'd0, 64'h0);
        add_row(CMD_INSERT, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 4'd4,
                64'h7F7F_7F7F_7F7F_7F7F, 0, ST_INSERTED, 4'd0, 64'h0);
        add_row(CMD_INSERT, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 4'd0,
                64'h0, 0, ST_INSERTED, 4'd0, 64'h0);
        add_row(CMD_DELETE, 16'h4321, 16'h0003, 16'h0000, 16'h0001, 16'h0000, 4'd0,
                64'h0, 1, ST_DELETED, 4'd0, 64'h0);

        for (int k = 0; k < KEY_POOL; k++)
        begin
            key_pool[k] = token_request('0, CMD_INSERT);
            key_pool[k].client   = ID_W'($urandom);
            key_pool[k].obj_id   = ID_W'($urandom);
            key_pool[k].inst_id  = ID_W'($urandom);
            key_pool[k].res_id   = ID_W'($urandom);
            key_pool[k].rinst_id = ID_W'($urandom);
            if (k > 0 && $urandom_range(0, 1) == 1)
            begin
                key_pool[k] = key_pool[k-1];
                case ($urandom_range(0, 4))
                    0: key_pool[k].client[$urandom_range(0, 15)] ^= 1'b1;
                    1: key_pool[k].obj_id[$urandom_range(0, 15)] ^= 1'b1;
                    2: key_pool[k].inst_id[$urandom_range(0, 15)] ^= 1'b1;
                    3: key_pool[k].res_id[$urandom_range(0, 15)] ^= 1'b1;
                    default: key_pool[k].rinst_id[$urandom_range(0, 15)] ^= 1'b1;
                endcase
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
        begin
            send_request(directed_rows[k].req, directed_rows[k].known, directed_rows[k].want);
        end

        // fill past capacity, then drain the same keys
        for (int pass = 0; pass < 2; pass++)
        begin
            for (int k = 0; k < ENTRIES + 4; k++)
            begin
                fill_key = '0;
                fill_key.client   = 16'hC000 + ID_W'(k);
                fill_key.obj_id   = ID_W'(k);
                fill_key.rinst_id = ~ID_W'(k);
                send_request(token_request(fill_key, pass == 0 ? CMD_INSERT : CMD_DELETE),
                             0, none);
            end
        end

        n = 0;
        for (int blk = 0; blk < RANDOM_ITEMS / 50; blk++)
        begin
            for (int j = 0; j < 50; j++)
            begin
                idle_on   = (n < RANDOM_ITEMS - QUIET_TAIL);
                do_insert = (blk % 2 == 0) ? ($urandom_range(0, 9) < 8)
                                           : ($urandom_range(0, 9) < 4);
                if ($urandom_range(0, 9) == 0)
                begin
                    r = '{do_insert ? CMD_INSERT : CMD_DELETE, ID_W'($urandom),
                          ID_W'($urandom), ID_W'($urandom), ID_W'($urandom),
                          ID_W'($urandom), LEN_W'($urandom), {$urandom, $urandom}};
                end
                else
                begin
                    r = token_request(key_pool[$urandom_range(0, KEY_POOL - 1)],
                                      do_insert ? CMD_INSERT : CMD_DELETE);
                end
                send_request(r, 0, none);
                n++;
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 8) @(posedge clk);

        $display("%0d items: %0d inserted, %0d already registered, %0d deleted,",
                 items_sent, status_seen[ST_INSERTED], status_seen[ST_ALREADY],
                 status_seen[ST_DELETED]);
        $display("%0d not found, %0d table full; %0d mismatches",
                 status_seen[ST_NOT_FOUND], status_seen[ST_FULL], mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
